FILE: rtl/core/iwd_pkg.sv
// Package for the instruction word decoder: format and operand-form codes,
// opcode constants, the opcode table and the decode result record.
// No dependencies.
package iwd_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned OpW   = 7;
	localparam int unsigned RegW  = 5;

	// Opcodes with special operand handling.
	localparam logic [OpW-1:0] OP_LOAD_LO = 7'h30;
	localparam logic [OpW-1:0] OP_LOAD_HI = 7'h34;
	localparam logic [OpW-1:0] OP_DEBUG   = 7'h52;
	localparam logic [OpW-1:0] OP_HALT    = 7'h7F;

	// Offset added on top of the immediate for branch targets.
	localparam logic [WordW-1:0] BranchOffset = 32'd4;

	// Instruction format classes.
	typedef enum logic [2:0] {
		FMT_R = 3'd0,
		FMT_I = 3'd1,
		FMT_S = 3'd2,
		FMT_B = 3'd3,
		FMT_U = 3'd4,
		FMT_J = 3'd5
	} fmt_t;

	// Operand-form codes.
	typedef enum logic [2:0] {
		FORM_NONE        = 3'd0,
		FORM_RS1_ONLY    = 3'd1,
		FORM_NORMAL      = 3'd2,
		FORM_LOAD        = 3'd3,
		FORM_JUMP_NOLINK = 3'd4
	} form_t;

	// Result of the opcode table lookup.
	typedef struct packed {
		logic known;
		fmt_t fmt;
	} op_class_t;

	// Decoded fields that come from the table, the immediate and the target.
	typedef struct packed {
		logic              known;
		fmt_t              fmt;
		form_t             form;
		logic [WordW-1:0]  imm;
		logic [WordW-1:0]  target;
		logic              has_target;
	} dec_t;

	// Fixed opcode table. Unknown opcodes report format R with known clear.
	function automatic op_class_t lookup_op(input logic [OpW-1:0] op);
		op_class_t res;
		res.known = 1'b1;
		res.fmt   = FMT_R;
		unique case (op) inside
			[7'h00:7'h0F]: res.fmt = FMT_R;
			[7'h10:7'h17]: res.fmt = FMT_I;
			[7'h18:7'h1D]: res.fmt = FMT_R;
			7'h1E:         res.fmt = FMT_I;
			7'h20:         res.fmt = FMT_U;
			[7'h30:7'h34]: res.fmt = FMT_I;
			[7'h38:7'h3A]: res.fmt = FMT_S;
			7'h3F:         res.fmt = FMT_R;
			7'h40:         res.fmt = FMT_J;
			7'h41:         res.fmt = FMT_I;
			[7'h48:7'h4D]: res.fmt = FMT_B;
			7'h50, 7'h51:  res.fmt = FMT_R;
			7'h52:         res.fmt = FMT_I;
			7'h7F:         res.fmt = FMT_R;
			default: begin
				res.known = 1'b0;
				res.fmt   = FMT_R;
			end
		endcase
		return res;
	endfunction

endpackage

FILE: rtl/core/iwd_decode.sv
// Combinational decode of one instruction word: table lookup, operand form,
// immediate assembly and control-transfer target. Depends on iwd_pkg.
module iwd_decode (
	input  logic [iwd_pkg::WordW-1:0] fetch_address,
	input  logic [iwd_pkg::WordW-1:0] word,
	output iwd_pkg::dec_t             dec
);
	import iwd_pkg::*;

	logic [OpW-1:0]   op;
	op_class_t        cls;
	logic [WordW-1:0] imm;
	logic [WordW-1:0] add_ofs;

	assign op  = word[OpW-1:0];
	assign cls = lookup_op(op);

	// Immediate in the layout of the format.
	always_comb begin
		case (cls.fmt)
			FMT_I:   imm = {{20{word[31]}}, word[31:20]};
			FMT_S:   imm = {{20{word[31]}}, word[31:25], word[11:7]};
			FMT_B:   imm = {{19{word[31]}}, word[31], word[7], word[30:25],
				word[11:8], 1'b0};
			FMT_U:   imm = {word[31:12], 12'h000};
			FMT_J:   imm = {{11{word[31]}}, word[31], word[19:12], word[20],
				word[30:21], 1'b0};
			default: imm = '0;
		endcase
	end

	// Branches are relative to the next word, jumps to the word itself.
	assign add_ofs = (cls.fmt == FMT_B) ? BranchOffset : '0;

	// Operand form, target and unknown-opcode masking.
	always_comb begin
		dec.known      = cls.known;
		dec.fmt        = cls.fmt;
		dec.imm        = cls.known ? imm : '0;
		dec.has_target = cls.known && (cls.fmt == FMT_B || cls.fmt == FMT_J);
		dec.target     = dec.has_target ? (fetch_address + imm + add_ofs) : '0;
		if (!cls.known || op == OP_HALT) begin
			dec.form = FORM_NONE;
		end else if (op == OP_DEBUG) begin
			dec.form = FORM_RS1_ONLY;
		end else if (op >= OP_LOAD_LO && op <= OP_LOAD_HI) begin
			dec.form = FORM_LOAD;
		end else if (cls.fmt == FMT_J && word[11:7] == 5'd0) begin
			dec.form = FORM_JUMP_NOLINK;
		end else begin
			dec.form = FORM_NORMAL;
		end
	end

endmodule

FILE: rtl/core/instruction_word_decoder.sv
// Top level of the instruction word decoder: input register, decode logic
// and result register with valid/stall handshakes. Depends on iwd_pkg and
// iwd_decode.
//
// Usage:
// A request carries fetch_address and word and is taken at a rising edge
// where req_valid is high and req_stall is low. Each request gives exactly
// one result, shown on the result ports while res_valid is high and taken
// at an edge where res_stall is low.
// Path: a request taken goes into the input register, and its decode is
// registered in the result register, which drives the result ports.
// Throughput: one request per cycle, sustained, as long as the receiver
// takes results; the decode is one pass through the table, the immediate
// mux and a 32-bit three-term add between the input and result registers.
// Stall: when the receiver stalls, the result register holds its value and
// the input register still accepts one more request; req_stall rises only
// when both registers are full and the result is not being taken.
// Reset: arst_n clears both valid flags; no result is pending afterward and
// a request can be taken at the first edge after reset is released.
module instruction_word_decoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [iwd_pkg::WordW-1:0] fetch_address,
	input  logic [iwd_pkg::WordW-1:0] word,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic                      known,
	output logic [iwd_pkg::OpW-1:0]   opcode,
	output logic [2:0]                format,
	output logic [2:0]                operand_form,
	output logic [iwd_pkg::RegW-1:0]  dest_reg,
	output logic [iwd_pkg::RegW-1:0]  src1_reg,
	output logic [iwd_pkg::RegW-1:0]  src2_reg,
	output logic signed [iwd_pkg::WordW-1:0] immediate,
	output logic [iwd_pkg::WordW-1:0] target,
	output logic                      has_target
);
	import iwd_pkg::*;

	logic             valid_s1;
	logic [WordW-1:0] addr_s1;
	logic [WordW-1:0] word_s1;
	logic             valid_s2;
	logic [WordW-1:0] word_s2;
	dec_t             dec_s2;
	dec_t             dec;
	logic             s2_free;
	logic             s1_free;
	logic             req_take;

	// Stage flow control.
	assign s2_free   = !valid_s2 || !res_stall;
	assign s1_free   = !valid_s1 || s2_free;
	assign req_stall = !s1_free;
	assign req_take  = req_valid && s1_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			addr_s1 <= fetch_address;
			word_s1 <= word;
		end
	end

	iwd_decode u_decode (
		.fetch_address (addr_s1),
		.word          (word_s1),
		.dec           (dec)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			word_s2 <= word_s1;
			dec_s2  <= dec;
		end
	end

	// Result ports.
	assign res_valid    = valid_s2;
	assign known        = dec_s2.known;
	assign opcode       = word_s2[OpW-1:0];
	assign format       = dec_s2.fmt;
	assign operand_form = dec_s2.form;
	assign dest_reg     = word_s2[11:7];
	assign src1_reg     = word_s2[19:15];
	assign src2_reg     = word_s2[24:20];
	assign immediate    = dec_s2.imm;
	assign target       = dec_s2.target;
	assign has_target   = dec_s2.has_target;

endmodule

FILE: rtl/core/iwd_checker.sv
// Port-level checks for the instruction word decoder, bound to the top
// level. Depends on iwd_pkg and instruction_word_decoder.
module iwd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      res_valid,
	input logic                      res_stall,
	input logic                      known,
	input logic [2:0]                format,
	input logic [2:0]                operand_form,
	input logic [iwd_pkg::WordW-1:0] immediate,
	input logic [iwd_pkg::WordW-1:0] target,
	input logic                      has_target
);
	import iwd_pkg::*;

	// A stalled result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// An unknown opcode gives the all-zero decode.
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !known |-> format == FMT_R && operand_form == FORM_NONE &&
			immediate == '0 && target == '0 && !has_target)
		else $error("unknown opcode with nonzero decode");

	// Only known branch and jump formats carry a target.
	a_target_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && has_target |-> known && (format == FMT_B || format == FMT_J))
		else $error("target flagged for a non-transfer format");

	// A jump without link is a J format, and upper immediates have clear low bits.
	a_form_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && operand_form == FORM_JUMP_NOLINK |-> format == FMT_J && has_target)
		else $error("jump-without-link form on a non-jump format");

	a_upper_imm: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && known && format == FMT_U |-> immediate[11:0] == 12'h000)
		else $error("upper immediate has low bits set");

endmodule

bind instruction_word_decoder iwd_checker u_iwd_checker (.*);
